FILE: hdl/idar_pkg.sv
package idar_pkg;

  localparam int unsigned COL_BITS = 3;
  localparam int unsigned ROW_WIDTH = 1 << COL_BITS;

  localparam logic FUNC_REQUEST  = 1'b0;
  localparam logic FUNC_SET_MODE = 1'b1;

  typedef struct packed {
    logic capture;
    logic commit;
    logic clr_step;
  } idar_cmd_t;

  typedef struct packed {
    logic out_free;
    logic leave;
    logic clr_last;
  } idar_sts_t;

endpackage

FILE: hdl/idar_req_if.sv
interface idar_req_if #(
  parameter int unsigned ID_BITS = 12
);
  logic               valid;
  logic               ready;
  logic               func;
  logic [ID_BITS-1:0] wished_id;
  logic               force_wish;
  logic               keep_ids;
  logic [ID_BITS-1:0] start_id;

  modport source (
    output valid, func, wished_id, force_wish, keep_ids, start_id,
    input  ready
  );
  modport sink (
    input  valid, func, wished_id, force_wish, keep_ids, start_id,
    output ready
  );
endinterface

FILE: hdl/idar_rsp_if.sv
interface idar_rsp_if #(
  parameter int unsigned ID_BITS = 12
);
  logic               valid;
  logic               ready;
  logic [ID_BITS-1:0] assigned_id;
  logic               wish_granted;
  logic               exhausted;

  modport source (
    output valid, assigned_id, wish_granted, exhausted,
    input  ready
  );
  modport sink (
    input  valid, assigned_id, wish_granted, exhausted,
    output ready
  );
endinterface

FILE: hdl/id_allocator_with_reservation_unit.sv
// Identifier allocator with wished ids and a keep mode backed by a used-id bitmap. A request
// beat has two steps: the accept cycle reads the bitmap row of the wished id from the
// synchronous bitmap memory; the decide step, once the result register is free, updates the
// counter, marks the bitmap in keep mode and loads the result register. A finished result
// may wait in its register while the next beat is accepted. A set-mode request with keep
// off, and reset, start a clearing pass that wipes one bitmap row of eight ids per cycle,
// during which no request is accepted. ID_BITS must be at least 4 and match both interfaces.
module id_allocator_with_reservation_unit #(
  parameter int unsigned ID_BITS = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  idar_req_if.sink   req_i,
  idar_rsp_if.source rsp_o
);
  import idar_pkg::*;

  idar_cmd_t cmd;
  idar_sts_t sts;
  logic      ready;

  assign req_i.ready = ready;

  idar_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  idar_dp #(
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .func_i       (req_i.func),
    .wished_id_i  (req_i.wished_id),
    .force_wish_i (req_i.force_wish),
    .keep_ids_i   (req_i.keep_ids),
    .start_id_i   (req_i.start_id),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .rsp_o        (rsp_o)
  );

endmodule

FILE: hdl/idar_ctrl.sv
module idar_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  idar_pkg::idar_sts_t   sts_i,
  output idar_pkg::idar_cmd_t   cmd_o
);
  import idar_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECIDE = 2'd1;
  localparam logic [1:0] ST_CLEAR  = 2'd2;

  logic [1:0] state_q, state_d;

  assign req_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d        = state_q;
    cmd_o.capture  = 1'b0;
    cmd_o.commit   = 1'b0;
    cmd_o.clr_step = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = sts_i.leave ? ST_CLEAR : ST_IDLE;
        end
      end
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/idar_dp.sv
module idar_dp #(
  parameter int unsigned ID_BITS = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                func_i,
  input  logic [ID_BITS-1:0]  wished_id_i,
  input  logic                force_wish_i,
  input  logic                keep_ids_i,
  input  logic [ID_BITS-1:0]  start_id_i,
  input  idar_pkg::idar_cmd_t cmd_i,
  output idar_pkg::idar_sts_t sts_o,
  idar_rsp_if.source          rsp_o
);
  import idar_pkg::*;

  localparam int unsigned ROW_BITS = ID_BITS - COL_BITS;
  localparam int unsigned ROWS     = 1 << ROW_BITS;

  logic [ROW_WIDTH-1:0] used_mem [ROWS];

  logic [ID_BITS:0]     next_id_q, next_id_d;
  logic                 keep_q, keep_d;
  logic                 func_q;
  logic [ID_BITS-1:0]   wish_q;
  logic                 force_q;
  logic                 keep_in_q;
  logic [ID_BITS-1:0]   start_q;
  logic [ROW_WIDTH-1:0] rdata_q;
  logic [ROW_BITS-1:0]  clr_row_q;

  logic                 out_valid_q;
  logic [ID_BITS-1:0]   out_id_q;
  logic                 out_granted_q;
  logic                 out_exh_q;

  logic                 wish_nz;
  logic                 marked;
  logic                 wish_ok;
  logic                 exh;
  logic [ID_BITS-1:0]   fresh_id;
  logic [ID_BITS-1:0]   mark_id;
  logic                 mark_we;
  logic                 mem_we;
  logic [ROW_BITS-1:0]  mem_waddr;
  logic [ROW_WIDTH-1:0] mem_wmask;
  logic [ROW_WIDTH-1:0] mem_wdata;
  logic [ID_BITS-1:0]   res_id;
  logic                 res_granted;
  logic                 res_exh;

  assign wish_nz  = (wish_q != '0);
  assign marked   = rdata_q[wish_q[COL_BITS-1:0]];
  assign fresh_id = next_id_q[ID_BITS-1:0];
  assign wish_ok  = wish_nz && (force_q ||
                    (keep_q ? !marked : ({1'b0, wish_q} >= next_id_q)));
  assign exh      = !wish_ok && next_id_q[ID_BITS];
  assign mark_id  = wish_ok ? wish_q : fresh_id;
  assign mark_we  = cmd_i.commit && (func_q == FUNC_REQUEST) && keep_q && !exh;

  always_comb begin
    next_id_d   = next_id_q;
    keep_d      = keep_q;
    res_id      = '0;
    res_granted = 1'b0;
    res_exh     = 1'b0;
    if (func_q == FUNC_SET_MODE) begin
      keep_d = keep_in_q;
      if (keep_in_q && (start_q > ID_BITS'(1))) begin
        next_id_d = {1'b0, start_q};
      end
    end else if (wish_ok) begin
      res_id      = wish_q;
      res_granted = 1'b1;
      if ({1'b0, wish_q} >= next_id_q) begin
        next_id_d = {1'b0, wish_q} + (ID_BITS+1)'(1);
      end
    end else if (exh) begin
      res_exh = 1'b1;
    end else begin
      res_id    = fresh_id;
      next_id_d = next_id_q + (ID_BITS+1)'(1);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = mark_id[ID_BITS-1:COL_BITS];
    mem_wmask = '0;
    mem_wdata = '1;
    if (cmd_i.clr_step) begin
      mem_we    = 1'b1;
      mem_waddr = clr_row_q;
      mem_wmask = '1;
      mem_wdata = '0;
    end else if (mark_we) begin
      mem_we                             = 1'b1;
      mem_wmask[mark_id[COL_BITS-1:0]]   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      for (int b = 0; b < ROW_WIDTH; b++) begin
        if (mem_wmask[b]) begin
          used_mem[mem_waddr][b] <= mem_wdata[b];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rdata_q <= used_mem[wished_id_i[ID_BITS-1:COL_BITS]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q    <= func_i;
      wish_q    <= wished_id_i;
      force_q   <= force_wish_i;
      keep_in_q <= keep_ids_i;
      start_q   <= start_id_i;
    end
    if (cmd_i.commit) begin
      out_id_q      <= res_id;
      out_granted_q <= res_granted;
      out_exh_q     <= res_exh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_id_q   <= (ID_BITS+1)'(1);
      keep_q      <= 1'b0;
      clr_row_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        next_id_q <= next_id_d;
        keep_q    <= keep_d;
      end
      if (cmd_i.clr_step) begin
        clr_row_q <= clr_row_q + ROW_BITS'(1);
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_free = !out_valid_q || rsp_o.ready;
  assign sts_o.leave    = (func_q == FUNC_SET_MODE) && !keep_in_q;
  assign sts_o.clr_last = (clr_row_q == '1);

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.assigned_id  = out_id_q;
  assign rsp_o.wish_granted = out_granted_q;
  assign rsp_o.exhausted    = out_exh_q;

endmodule
